### hw/rtl/prd_pkg.sv
// Shared constants, codes and pipeline types of the phase reference deviation unit.
package prd_pkg;

    localparam int DIM_DEF    = 6;
    localparam int MAX_WP_DEF = 64;

    localparam int NCOORD = 6;   // coordinate fields on the input request
    localparam int CW     = 24;  // Q8.16 coordinate width
    localparam int PW     = 32;  // Q16.16 phase width
    localparam int WPIW   = 6;   // waypoint index field width
    localparam int CIW    = 3;   // coordinate index field width
    localparam int FW     = 16;  // interpolation fraction width
    localparam int DW     = 25;  // coordinate difference width
    localparam int SQW    = 48;  // squared difference width
    localparam int SUMW   = 51;  // square sum width
    localparam int RW     = 26;  // root width
    localparam int CNTW   = 7;   // waypoint count register width
    localparam int SDW    = 216; // input tdata width
    localparam int MDW    = 32;  // output tdata width

    localparam logic [1:0] CFG_WP_COUNT    = 2'd0;
    localparam logic [1:0] CFG_PHASE_RECIP = 2'd1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic [NCOORD-1:0][CW-1:0] coord_vec_t;

    typedef struct packed {
        logic             valid;
        logic             kind;
        logic [WPIW-1:0]  wp;
        logic [CIW-1:0]   ci;
        logic [CW-1:0]    load_value;
        coord_vec_t       coords;
    } item_t;

    typedef struct packed {
        item_t           item;
        logic            clamped;
        logic [FW-1:0]   frac;
    } lookup_t;

    typedef struct packed {
        logic            valid;
        logic            clamped;
        logic [SUMW-1:0] sum;
    } sum_t;

    typedef struct packed {
        logic            valid;
        logic            clamped;
        logic [RW-1:0]   root;
    } root_t;

endpackage

### hw/rtl/prd_ram.sv
// Generic RAM with one write port and two registered read ports.
module prd_ram import prd_pkg::*; #(
    parameter int WIDTH = CW,
    parameter int DEPTH = MAX_WP_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

### hw/rtl/prd_phase.sv
// Phase scaling, clamping and mapping onto the waypoint polyline (three stages).
module prd_phase import prd_pkg::*; #(
    parameter int MAX_WAYPOINTS = MAX_WP_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  item_t                            in_item,
    input  logic [PW-1:0]                    in_phase,
    input  logic [PW-1:0]                    recip,
    input  logic [$clog2(MAX_WAYPOINTS)-1:0] nm1,
    output lookup_t                          lk,
    output logic [$clog2(MAX_WAYPOINTS)-1:0] low,
    output logic [$clog2(MAX_WAYPOINTS)-1:0] high
);

    localparam int WPW = $clog2(MAX_WAYPOINTS);
    localparam int MW  = 33 + WPW;

    item_t                s1_reg, s2_reg, s3_reg;
    logic signed [63:0]   prod_reg, prod_next;
    logic [32:0]          alpha_reg, alpha_next;
    logic                 clamp2_reg, clamp2_next, clamp3_reg;
    logic [MW-1:0]        pos;
    logic [WPW-1:0]       low_reg, low_next, high_reg, high_next;
    logic [FW-1:0]        frac_reg;

    assign prod_next = 64'($signed(in_phase)) * 64'($signed({1'b0, recip}));

    always_comb begin
        if (prod_reg < 64'sd0) begin
            alpha_next  = '0;
            clamp2_next = 1'b1;
        end else if (prod_reg > 64'sd4294967296) begin
            alpha_next  = 33'h1_0000_0000;
            clamp2_next = 1'b1;
        end else begin
            alpha_next  = prod_reg[32:0];
            clamp2_next = 1'b0;
        end
    end

    // The scaled phase never exceeds one, so the segment never passes the last waypoint.
    assign pos       = MW'(alpha_reg) * MW'(nm1);
    assign low_next  = pos[32 +: WPW];
    assign high_next = (low_next < nm1) ? low_next + 1'b1 : nm1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
            s3_reg.valid <= 1'b0;
        end else if (en) begin
            s1_reg.valid <= in_item.valid;
            s2_reg.valid <= s1_reg.valid;
            s3_reg.valid <= s2_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg.kind       <= in_item.kind;
            s1_reg.wp         <= in_item.wp;
            s1_reg.ci         <= in_item.ci;
            s1_reg.load_value <= in_item.load_value;
            s1_reg.coords     <= in_item.coords;
            prod_reg          <= prod_next;
            s2_reg.kind       <= s1_reg.kind;
            s2_reg.wp         <= s1_reg.wp;
            s2_reg.ci         <= s1_reg.ci;
            s2_reg.load_value <= s1_reg.load_value;
            s2_reg.coords     <= s1_reg.coords;
            alpha_reg         <= alpha_next;
            clamp2_reg        <= clamp2_next;
            s3_reg.kind       <= s2_reg.kind;
            s3_reg.wp         <= s2_reg.wp;
            s3_reg.ci         <= s2_reg.ci;
            s3_reg.load_value <= s2_reg.load_value;
            s3_reg.coords     <= s2_reg.coords;
            clamp3_reg        <= clamp2_reg;
            low_reg           <= low_next;
            high_reg          <= high_next;
            frac_reg          <= pos[31:16];
        end
    end

    assign lk.item    = s3_reg;
    assign lk.clamped = clamp3_reg;
    assign lk.frac    = frac_reg;
    assign low        = low_reg;
    assign high       = high_reg;

endmodule

### hw/rtl/prd_interp.sv
// Interpolation, differences, squares and their sum (three stages).
module prd_interp import prd_pkg::*; #(
    parameter int DIM = DIM_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  lookup_t       lk,
    input  logic [CW-1:0] wa [DIM],
    input  logic [CW-1:0] wb [DIM],
    output sum_t          res
);

    logic signed [DW-1:0]   d_reg [DIM];
    logic signed [DW-1:0]   d_next [DIM];
    logic [SQW-1:0]         sq_reg [DIM];
    logic [SQW-1:0]         sq_next [DIM];
    logic signed [DW-1:0]   diff [DIM];
    logic signed [41:0]     pr [DIM];
    logic signed [25:0]     refv [DIM];
    logic signed [25:0]     dfull [DIM];
    logic signed [49:0]     sqf [DIM];
    logic [SUMW-1:0]        sum_next, sum_reg;
    logic                   v5_reg, v6_reg, v7_reg;
    logic                   c5_reg, c6_reg, c7_reg;

    // ref = a + floor((b - a) * frac / 2^16), the same as the two-weight form.
    always_comb begin
        for (int i = 0; i < DIM; i++) begin
            diff[i]   = DW'($signed(wb[i])) - DW'($signed(wa[i]));
            pr[i]     = 42'(diff[i]) * 42'($signed({1'b0, lk.frac}));
            refv[i]   = 26'($signed(wa[i])) + 26'(pr[i] >>> 16);
            dfull[i]  = 26'($signed(lk.item.coords[i])) - refv[i];
            d_next[i] = dfull[i][DW-1:0];
            sqf[i]    = 50'(d_reg[i]) * 50'(d_reg[i]);
            sq_next[i] = sqf[i][SQW-1:0];
        end
    end

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < DIM; i++) begin
            sum_next = sum_next + SUMW'(sq_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= lk.item.valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg   <= d_next;
            sq_reg  <= sq_next;
            sum_reg <= sum_next;
            c5_reg  <= lk.clamped;
            c6_reg  <= c5_reg;
            c7_reg  <= c6_reg;
        end
    end

    assign res.valid   = v7_reg;
    assign res.clamped = c7_reg;
    assign res.sum     = sum_reg;

endmodule

### hw/rtl/prd_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module prd_sqrt import prd_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  sum_t  sin,
    output root_t rout
);

    localparam int TW = SUMW + 3;

    logic [SUMW-1:0] rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic            v_reg    [RW];
    logic            c_reg    [RW];

    for (genvar k = 0; k < RW; k++) begin : g_bit
        localparam int B = RW - 1 - k;
        logic [SUMW-1:0] rem_in, rem_next;
        logic [RW-1:0]   root_in, root_next;
        logic            v_in, c_in, take;
        logic [TW-1:0]   test;

        if (k == 0) begin : g_first
            assign rem_in  = sin.sum;
            assign root_in = '0;
            assign v_in    = sin.valid;
            assign c_in    = sin.clamped;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign v_in    = v_reg[k-1];
            assign c_in    = c_reg[k-1];
        end

        // Remainder holds x - root^2; setting bit B costs root*2^(B+1) + 2^(2B).
        assign test      = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
        assign take      = TW'(rem_in) >= test;
        assign rem_next  = take ? SUMW'(TW'(rem_in) - test) : rem_in;
        assign root_next = take ? (root_in | (RW'(1) << B)) : root_in;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                c_reg[k]    <= c_in;
            end
        end
    end

    assign rout.valid   = v_reg[RW-1];
    assign rout.clamped = c_reg[RW-1];
    assign rout.root    = root_reg[RW-1];

endmodule

### hw/rtl/phase_reference_deviation_unit.sv
// Top level of the phase reference deviation unit: distance of a point from a phase-indexed path.
// Requests arrive on the s_ stream. s_tuser is the kind: a load request writes one coordinate of
// one waypoint into the waypoint table and gives no result; a query request carries a Q16.16 phase
// and a six-coordinate Q8.16 point and gives exactly one result on the m_ stream, the truncated
// Euclidean distance (Q10.16) between the point and the linearly interpolated waypoint path,
// with m_tuser flagging that the scaled phase had to be clamped to the range zero to one.
// Results leave in request order. A load and a later query are ordered as they arrive.
// The cfg_ channel writes waypoint_count (index 0) and phase_scale_recip (index 1); it is always
// ready and should only be used while the pipeline is empty. Other indices are ignored.
// Throughput is one request per cycle while no result waits on a stalled receiver. A query's
// result passes through three phase stages, one table read, three arithmetic stages, 26 root
// stages (one root bit each) and the output register before it appears on m_tvalid.
// When the receiver stalls with a result waiting, the whole pipeline holds and s_tready drops;
// nothing is lost or repeated. Reset (aresetn low, synchronous) empties the pipeline and restores
// waypoint_count to 2 and the scale to one; the table contents are undefined until loaded, and
// a query must not touch a waypoint coordinate that has never been written.
module phase_reference_deviation_unit import prd_pkg::*; #(
    parameter int DIM           = DIM_DEF,
    parameter int MAX_WAYPOINTS = MAX_WP_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // wp_index[5:0], coord_index[8:6], load_value[32:9], phase[64:33], coord_0[88:65],
    // coord_1[112:89], coord_2[136:113], coord_3[160:137], coord_4[184:161], coord_5[208:185]
    input  logic [SDW-1:0]   s_tdata,
    input  logic             s_tuser,   // kind[0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [MDW-1:0]   m_tdata,   // deviation[25:0]
    output logic             m_tuser,   // phase_clamped[0]
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [PW-1:0]    cfg_data
);

    localparam int WPW = $clog2(MAX_WAYPOINTS);

    logic            en;
    item_t           in_item;
    lookup_t         lk, s4_reg;
    logic [WPW-1:0]  low, high;
    logic [WPW-1:0]  nm1_reg;
    logic [WPW-1:0]  nm1_next;
    logic [PW-1:0]   recip_reg;
    logic            wr_ok;
    logic [CW-1:0]   wa [DIM];
    logic [CW-1:0]   wb [DIM];
    sum_t            sum_s;
    root_t           root_s;
    logic            out_valid_reg;
    logic [RW-1:0]   dev_reg;
    logic            clamp_reg;
    int              cnt;

    // The whole pipeline advances unless a finished result is waiting on a stalled receiver.
    assign en        = !out_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    assign in_item.valid      = s_tvalid;
    assign in_item.kind       = s_tuser;
    assign in_item.wp         = s_tdata[5:0];
    assign in_item.ci         = s_tdata[8:6];
    assign in_item.load_value = s_tdata[32:9];
    for (genvar i = 0; i < NCOORD; i++) begin : g_coord
        assign in_item.coords[i] = s_tdata[65 + i*CW +: CW];
    end

    // The waypoint count is held as its last waypoint index, already limited to the table.
    always_comb begin
        cnt = int'(cfg_data[CNTW-1:0]);
        if (cnt < 2) begin
            cnt = 2;
        end else if (cnt > MAX_WAYPOINTS) begin
            cnt = MAX_WAYPOINTS;
        end
        nm1_next = WPW'(cnt - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nm1_reg   <= WPW'(1);
            recip_reg <= PW'(65536);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WP_COUNT:    nm1_reg   <= nm1_next;
                CFG_PHASE_RECIP: recip_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    prd_phase #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_phase (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_item  (in_item),
        .in_phase (s_tdata[64:33]),
        .recip    (recip_reg),
        .nm1      (nm1_reg),
        .lk       (lk),
        .low      (low),
        .high     (high)
    );

    // Loads are written at the same stage where queries read, so table order follows request order.
    assign wr_ok = en && lk.item.valid && (lk.item.kind == KIND_LOAD)
                && (32'(lk.item.wp) < 32'(MAX_WAYPOINTS));

    for (genvar g = 0; g < DIM; g++) begin : g_col
        prd_ram #(.WIDTH(CW), .DEPTH(MAX_WAYPOINTS)) u_ram (
            .aclk    (aclk),
            .we      (wr_ok && (32'(lk.item.ci) == g)),
            .waddr   (WPW'(lk.item.wp)),
            .wdata   (lk.item.load_value),
            .re      (en),
            .raddr_a (low),
            .raddr_b (high),
            .rdata_a (wa[g]),
            .rdata_b (wb[g])
        );
    end

    // Stage alongside the table read; only queries travel further.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_reg.item.valid <= 1'b0;
        end else if (en) begin
            s4_reg.item.valid <= lk.item.valid && (lk.item.kind == KIND_QUERY);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_reg.item.kind       <= lk.item.kind;
            s4_reg.item.wp         <= lk.item.wp;
            s4_reg.item.ci         <= lk.item.ci;
            s4_reg.item.load_value <= lk.item.load_value;
            s4_reg.item.coords     <= lk.item.coords;
            s4_reg.clamped         <= lk.clamped;
            s4_reg.frac            <= lk.frac;
        end
    end

    prd_interp #(.DIM(DIM)) u_interp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .lk      (s4_reg),
        .wa      (wa),
        .wb      (wb),
        .res     (sum_s)
    );

    prd_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .sin     (sum_s),
        .rout    (root_s)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= root_s.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dev_reg   <= root_s.root;
            clamp_reg <= root_s.clamped;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = MDW'(dev_reg);
    assign m_tuser  = clamp_reg;

endmodule

### verif/prd_deviation_checker.sv
// Checker of the phase reference deviation unit: predicts every query result and compares it.
module prd_deviation_checker import prd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [SDW-1:0]   s_tdata,
    input  logic             s_tuser,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [MDW-1:0]   m_tdata,
    input  logic             m_tuser,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [PW-1:0]    cfg_data,
    output int               mismatches,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_Q32 = 64'sh1_0000_0000;

    typedef struct packed {
        logic [RW-1:0] deviation;
        logic          clamped;
    } deviation_t;

    logic signed [CW-1:0] wp_table [MAX_WP_DEF*DIM_DEF];
    logic [CNTW-1:0]      wp_count;
    logic [PW-1:0]        phase_recip;
    deviation_t           expected_results [$];

    assign outstanding = expected_results.size();

    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Scale and clamp the phase, interpolate between the two neighbouring waypoints and take
    // the truncated root of the summed squared differences.
    function automatic deviation_t deviation_of(logic [PW-1:0] ph, coord_vec_t pt);
        longint n, prod, alpha, pos, low, high, frac, a, b, rv, d;
        longint unsigned sum, root;
        deviation_t r;
        n = (wp_count < 2) ? 2 : (wp_count > MAX_WP_DEF) ? MAX_WP_DEF : longint'(wp_count);
        prod = longint'($signed(ph)) * longint'({32'b0, phase_recip});
        r.clamped = (prod < 0) || (prod > ONE_Q32);
        alpha = (prod < 0) ? 0 : (prod > ONE_Q32) ? ONE_Q32 : prod;
        pos = (alpha * (n - 1)) >>> 16;
        low = pos >>> 16;
        frac = pos & 64'hFFFF;
        if (low > n - 1) low = n - 1;
        high = (low + 1 < n - 1) ? low + 1 : n - 1;
        sum = 0;
        for (int i = 0; i < DIM_DEF; i++) begin
            a = longint'(wp_table[low*DIM_DEF + i]);
            b = longint'(wp_table[high*DIM_DEF + i]);
            rv = (a * (65536 - frac) + b * frac) >>> 16;
            d = longint'($signed(pt[i])) - rv;
            sum += longint'(d * d);
        end
        root = int_root(sum);
        r.deviation = root[RW-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        deviation_t got, want;
        logic [WPIW-1:0] wp;
        logic [CIW-1:0]  ci;
        if (!aresetn) begin
            for (int i = 0; i < MAX_WP_DEF*DIM_DEF; i++) wp_table[i] = '0;
            wp_count = 7'd2;
            phase_recip = 32'd65536;
            expected_results.delete();
            mismatches = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.deviation = m_tdata[RW-1:0];
                got.clamped = m_tuser;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result deviation=%0d clamped=%0b",
                                 $realtime, got.deviation, got.clamped);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want || m_tdata[MDW-1:RW] !== '0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result mismatch: expected deviation=%0d clamped=%0b",
                                     $realtime, want.deviation, want.clamped,
                                     ", got deviation=%0d clamped=%0b tdata=%h",
                                     got.deviation, got.clamped, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == KIND_LOAD) begin
                    wp = s_tdata[5:0];
                    ci = s_tdata[8:6];
                    // Columns beyond the point's dimension are dropped by the block.
                    if (ci < DIM_DEF && wp < MAX_WP_DEF)
                        wp_table[wp*DIM_DEF + ci] = s_tdata[32:9];
                end else begin
                    expected_results = {expected_results,
                                        deviation_of(s_tdata[64:33], s_tdata[208:65])};
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_WP_COUNT) wp_count = cfg_data[CNTW-1:0];
                else if (cfg_index == CFG_PHASE_RECIP) phase_recip = cfg_data;
            end
        end
    end
endmodule

### verif/tb_phase_reference_deviation_unit.sv
// Testbench top of the phase reference deviation unit: stimulus, idling and the verdict.
module tb_phase_reference_deviation_unit;
    import prd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indices past the end of the list, which the block must ignore.
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;
    localparam int         LATENCY     = 34;
    localparam int         CYCLE_LIMIT = 400000;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [SDW-1:0]   s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [MDW-1:0]   m_tdata;
    logic             m_tuser;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [PW-1:0]    cfg_data;

    int               mismatches;
    int               outstanding;
    int               cycles = 0;
    int               tx_idle_pct;
    int               rx_idle_pct;
    logic [PW-1:0]    cur_recip;

    phase_reference_deviation_unit u_dut (.*);

    prd_deviation_checker u_checker (.*);

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // The receiver stalls at random with the rate that the current phase of the run sets.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [SDW-1:0] pack_request(logic [WPIW-1:0] wp, logic [CIW-1:0] ci,
                                                    logic [CW-1:0] value, logic [PW-1:0] ph,
                                                    coord_vec_t pt);
        return {7'b0, pt, ph, value, ci, wp};
    endfunction

    function automatic coord_vec_t random_point();
        coord_vec_t pt;
        for (int i = 0; i < NCOORD; i++) pt[i] = CW'($urandom());
        return pt;
    endfunction

    // Picks a raw phase whose scaled value lands inside the path, so the interpolation is
    // exercised; a few requests use any phase at all to hit the clamp.
    function automatic logic [PW-1:0] random_phase();
        longint target;
        if (cur_recip == 0 || $urandom_range(0, 3) == 0) return $urandom();
        target = longint'($urandom_range(0, 65536)) << 16;
        return PW'(target / longint'({32'b0, cur_recip}));
    endfunction

    // Offers one request; a random gap may come first. Holds it until it is accepted, and
    // leaves it offered so that the next request can follow without a gap.
    task automatic send(logic kind, logic [SDW-1:0] data);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic load(logic [WPIW-1:0] wp, logic [CIW-1:0] ci, logic [CW-1:0] value);
        send(KIND_LOAD, pack_request(wp, ci, value, PW'($urandom()), random_point()));
    endtask

    task automatic query(logic [PW-1:0] ph, coord_vec_t pt);
        send(KIND_QUERY, pack_request(WPIW'($urandom()), CIW'($urandom()), CW'($urandom()),
                                      ph, pt));
    endtask

    // Waits for the pipeline to empty; loads give no result, so the latency is waited out too.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (LATENCY + 6) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [PW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_PHASE_RECIP) cur_recip = value;
    endtask

    initial begin
        coord_vec_t hi_pt, lo_pt;
        logic [CNTW-1:0] counts [6];
        logic [PW-1:0]   recips [6];
        for (int i = 0; i < NCOORD; i++) begin
            hi_pt[i] = 24'h7FFFFF;
            lo_pt[i] = 24'h800000;
        end
        counts = '{7'd64, 7'd2, 7'd0, 7'd127, 7'd17, 7'd1};
        recips = '{32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd32768, 32'd200000};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_LOAD;
        cfg_valid = 1'b0;
        cfg_index = CFG_WP_COUNT;
        cfg_data = '0;
        tx_idle_pct = 11;
        rx_idle_pct = 77;
        cur_recip = 32'd65536;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every table entry is written before any query, so no query reads an unwritten one.
        for (int w = 0; w < MAX_WP_DEF; w++)
            for (int c = 0; c < DIM_DEF; c++)
                load(WPIW'(w), CIW'(c), CW'($urandom()));

        // Directed requests under the reset settings: two waypoints and a scale of one.
        query(32'd0, hi_pt);
        query(32'd65536, lo_pt);              // exactly one is not clamped
        query(32'd65537, hi_pt);              // just above one is clamped
        query(32'd32768, random_point());
        query(32'h8000_0000, lo_pt);          // most negative phase
        query(32'h7FFF_FFFF, hi_pt);          // largest phase
        query(32'hFFFF_FFFF, random_point()); // just below zero
        load(6'd0, 3'd6, 24'h7FFFFF);         // columns past the dimension are ignored
        load(6'd1, 3'd7, 24'h800000);
        load(6'd0, 3'd0, 24'h7FFFFF);
        load(6'd1, 3'd5, 24'h800000);
        query(32'd16384, lo_pt);              // sees the loads just before it
        load(6'd63, 3'd0, 24'h800000);
        load(6'd63, 3'd5, 24'h7FFFFF);
        query(32'd49152, hi_pt);
        drain();
        write_reg(CFG_WP_COUNT, 32'd64);
        write_reg(CFG_SPARE_A, 32'd1);
        write_reg(CFG_SPARE_B, 32'hFFFF_FFFF);
        query(32'd65536, lo_pt);              // last waypoint alone
        query(32'd65535, hi_pt);
        query(32'd1040, random_point());
        query(32'd0, random_point());

        // Random part in six phases, each with its own settings; idling changes every two.
        for (int p = 0; p < 6; p++) begin
            drain();
            tx_idle_pct = (p < 2) ? 11 : (p < 4) ? 77 : 0;
            rx_idle_pct = (p < 2) ? 77 : (p < 4) ? 11 : 0;
            write_reg(CFG_WP_COUNT, PW'(counts[p]));
            write_reg(CFG_PHASE_RECIP, recips[p]);
            for (int k = 0; k < 10; k++) begin
                if ($urandom_range(0, 9) < 3)
                    load(WPIW'($urandom()), CIW'($urandom()), CW'($urandom()));
                else
                    query(random_phase(), random_point());
            end
        end

        drain();
        if (mismatches == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

### files.f
hw/rtl/prd_pkg.sv
hw/rtl/prd_ram.sv
hw/rtl/prd_phase.sv
hw/rtl/prd_interp.sv
hw/rtl/prd_sqrt.sv
hw/rtl/phase_reference_deviation_unit.sv
verif/prd_deviation_checker.sv
verif/tb_phase_reference_deviation_unit.sv
